>>> rtl/fdm_pkg.sv
// ---------------------------------------------------------------------------
// fdm_pkg
// shared types and constants of the filtered differential drive mixer
// ---------------------------------------------------------------------------
package fdm_pkg;

  // boxcar window length per axis
  localparam int WINDOW      = 30;
  localparam int SAMPLE_W    = 10;
  localparam int DUTY_W      = 8;
  localparam int SUM_W       = $clog2(WINDOW * 1023 + 1);

  // floor(sum / WINDOW) as a multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W     = DIV_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'((2 ** DIV_SHIFT + WINDOW - 1) / WINDOW);

  // reset contents
  localparam logic [SAMPLE_W-1:0] WINDOW_FILL   = SAMPLE_W'(511);
  localparam logic [SUM_W-1:0]    SUM_RESET     = SUM_W'(WINDOW * 511);
  localparam logic [SAMPLE_W-1:0] CENTRE_RESET  = SAMPLE_W'(511);
  localparam logic [SAMPLE_W-1:0] DB_HIGH_RESET = SAMPLE_W'(531);
  localparam logic [SAMPLE_W-1:0] DB_LOW_RESET  = SAMPLE_W'(451);

  // motor value where forward and backward duty start counting
  localparam logic [SAMPLE_W-1:0] FWD_ZERO = SAMPLE_W'(513);
  localparam logic [SAMPLE_W-1:0] BWD_ZERO = SAMPLE_W'(510);

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REG_CENTRE  = 2'd0,
    REG_DB_HIGH = 2'd1,
    REG_DB_LOW  = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BWD  = 2'd2
  } direction_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] vertical_sample;
    logic [SAMPLE_W-1:0] horizontal_sample;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    direction_t        left_direction;
    logic [DUTY_W-1:0] right_duty;
    direction_t        right_direction;
  } motor_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    direction_t        direction;
  } motor_side_t;

  typedef struct packed {
    logic [SUM_W-1:0] vertical_sum;
    logic [SUM_W-1:0] horizontal_sum;
  } sums_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] centre_value;
    logic [SAMPLE_W-1:0] deadband_high;
    logic [SAMPLE_W-1:0] deadband_low;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> rtl/fdm_front.sv
// ---------------------------------------------------------------------------
// fdm_front
// sample intake: boxcar shift lines and running sums per axis
// ---------------------------------------------------------------------------
module fdm_front import fdm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          sample_valid,
  output logic          sample_stall,
  input  sample_t       sample,
  input  queue_status_t q_status,
  output logic          push,
  output sums_t         entry
);

  logic [SAMPLE_W-1:0] vwin [WINDOW];
  logic [SAMPLE_W-1:0] hwin [WINDOW];
  logic [SUM_W-1:0]    vsum;
  logic [SUM_W-1:0]    hsum;
  logic [SUM_W-1:0]    vsum_next;
  logic [SUM_W-1:0]    hsum_next;

  assign sample_stall = q_status.full;
  assign push         = sample_valid && !q_status.full;

  // oldest sample leaves at the far tap
  assign vsum_next = vsum - SUM_W'(vwin[WINDOW-1]) + SUM_W'(sample.vertical_sample);
  assign hsum_next = hsum - SUM_W'(hwin[WINDOW-1]) + SUM_W'(sample.horizontal_sample);

  assign entry.vertical_sum   = vsum_next;
  assign entry.horizontal_sum = hsum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vsum <= SUM_RESET;
      hsum <= SUM_RESET;
      for (int i = 0; i < WINDOW; i++) begin
        vwin[i] <= WINDOW_FILL;
        hwin[i] <= WINDOW_FILL;
      end
    end else if (push) begin
      vsum    <= vsum_next;
      hsum    <= hsum_next;
      vwin[0] <= sample.vertical_sample;
      hwin[0] <= sample.horizontal_sample;
      for (int i = 1; i < WINDOW; i++) begin
        vwin[i] <= vwin[i-1];
        hwin[i] <= hwin[i-1];
      end
    end
  end

endmodule

>>> rtl/fdm_queue.sv
// ---------------------------------------------------------------------------
// fdm_queue
// short first-word-fall-through queue of running sums
// ---------------------------------------------------------------------------
module fdm_queue import fdm_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sums_t         entry_in,
  input  logic          pop,
  output sums_t         entry_out,
  output queue_status_t status
);

  sums_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wptr;
  logic [QUEUE_AW-1:0]  rptr;
  logic [QUEUE_CW-1:0]  count;

  assign status.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign entry_out    = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= entry_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/fdm_back.sv
// ---------------------------------------------------------------------------
// fdm_back
// averaging, steering mix and motor mapping, three registered stages
// ---------------------------------------------------------------------------
module fdm_back import fdm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  sums_t  entry,
  input  logic   q_empty,
  output logic   pop,
  output logic   motor_valid,
  input  logic   motor_stall,
  output motor_t motor
);

  // stage 1: averages, stage 2: motor values, stage 3: output register
  logic                v1, v2, v3;
  logic                rdy1, rdy2, rdy3;
  logic [SAMPLE_W-1:0] vavg, havg;
  logic [SAMPLE_W-1:0] left_val, right_val;
  logic [PROD_W-1:0]   vprod, hprod;

  logic                  steer;
  logic signed [SAMPLE_W:0]   offset;
  logic signed [SAMPLE_W:0]   half;
  logic signed [SAMPLE_W+1:0] left_wide, right_wide;
  logic [SAMPLE_W-1:0]        left_mix, right_mix;
  motor_side_t                left_side, right_side;

  function automatic logic [SAMPLE_W-1:0] clamp10(input logic signed [SAMPLE_W+1:0] x);
    logic [SAMPLE_W-1:0] r;
    if (x[SAMPLE_W+1]) begin
      r = '0;
    end else if (x[SAMPLE_W]) begin
      r = '1;
    end else begin
      r = x[SAMPLE_W-1:0];
    end
    return r;
  endfunction

  function automatic motor_side_t drive_side(input logic [SAMPLE_W-1:0] m,
                                             input logic [SAMPLE_W-1:0] db_high,
                                             input logic [SAMPLE_W-1:0] db_low);
    motor_side_t       s;
    logic [SAMPLE_W:0] fwd_diff;
    logic [SAMPLE_W:0] bwd_diff;
    fwd_diff = {1'b0, m} - {1'b0, FWD_ZERO};
    bwd_diff = {1'b0, BWD_ZERO} - {1'b0, m};
    // forward test first, so it wins when the deadband is crossed
    if (m > db_high) begin
      s.direction = DIR_FWD;
      s.duty      = (m > FWD_ZERO) ? fwd_diff[DUTY_W:1] : '0;
    end else if (m < db_low) begin
      s.direction = DIR_BWD;
      s.duty      = (m < BWD_ZERO) ? bwd_diff[DUTY_W:1] : '0;
    end else begin
      s.direction = DIR_STOP;
      s.duty      = '0;
    end
    return s;
  endfunction

  assign rdy3 = !v3 || !motor_stall;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign pop  = !q_empty && rdy1;

  assign vprod = PROD_W'(entry.vertical_sum) * PROD_W'(DIV_RECIP);
  assign hprod = PROD_W'(entry.horizontal_sum) * PROD_W'(DIV_RECIP);

  // steering mix
  assign steer  = (havg > cfg.deadband_high) || (havg < cfg.deadband_low);
  assign offset = $signed({1'b0, havg}) - $signed({1'b0, cfg.centre_value});
  // halve, rounding toward zero
  assign half   = (offset + $signed({{SAMPLE_W{1'b0}}, offset[SAMPLE_W]})) >>> 1;
  assign left_wide  = $signed({2'b00, vavg}) - $signed({half[SAMPLE_W], half});
  assign right_wide = $signed({2'b00, vavg}) + $signed({half[SAMPLE_W], half});
  assign left_mix   = steer ? clamp10(left_wide)  : vavg;
  assign right_mix  = steer ? clamp10(right_wide) : vavg;

  assign left_side  = drive_side(left_val,  cfg.deadband_high, cfg.deadband_low);
  assign right_side = drive_side(right_val, cfg.deadband_high, cfg.deadband_low);

  assign motor_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= pop;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      vavg <= vprod[DIV_SHIFT +: SAMPLE_W];
      havg <= hprod[DIV_SHIFT +: SAMPLE_W];
    end
    if (v1 && rdy2) begin
      left_val  <= left_mix;
      right_val <= right_mix;
    end
    if (v2 && rdy3) begin
      motor.left_duty       <= left_side.duty;
      motor.left_direction  <= left_side.direction;
      motor.right_duty      <= right_side.duty;
      motor.right_direction <= right_side.direction;
    end
  end

endmodule

>>> rtl/filtered_differential_drive_mixer_unit.sv
// ---------------------------------------------------------------------------
// filtered_differential_drive_mixer_unit
// joystick pair in, moving-average filter, arcade mix, two motor duties out
// ---------------------------------------------------------------------------
//
//   channel  direction  handshake                 payload
//   sample   in         sample_valid/sample_stall sample_t (vertical, horizontal)
//   motor    out        motor_valid/motor_stall   motor_t (duty and direction x2)
//   cfg      in         cfg_we                    cfg_index, cfg_data
//
// one sample transfer per cycle sustained while sample_stall is low; a result
// leaves through the queue write, divide, mix and map registers, in that order
// the front updates window shift lines and running sums in the transfer cycle
// and a four-entry queue feeds the three-stage back pipeline
// synchronous reset fills both windows with 511 directly, no clearing pass
// motor stalls fill the back stages, then the queue; only a full queue raises sample_stall
//
module filtered_differential_drive_mixer_unit import fdm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  // sample channel
  input  logic                sample_valid,
  output logic                sample_stall,
  input  sample_t             sample,
  // motor channel
  output logic                motor_valid,
  input  logic                motor_stall,
  output motor_t              motor,
  // configuration writes
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  cfg_t          cfg;
  sums_t         front_entry;
  sums_t         back_entry;
  queue_status_t q_status;
  logic          q_push;
  logic          q_pop;

  // configuration registers, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_value  <= CENTRE_RESET;
      cfg.deadband_high <= DB_HIGH_RESET;
      cfg.deadband_low  <= DB_LOW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE:  cfg.centre_value  <= cfg_data;
        REG_DB_HIGH: cfg.deadband_high <= cfg_data;
        REG_DB_LOW:  cfg.deadband_low  <= cfg_data;
        default:     cfg <= cfg;
      endcase
    end
  end

  // front: window update and running sums
  fdm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_status     (q_status),
    .push         (q_push),
    .entry        (front_entry)
  );

  // decoupling queue between intake and motor pipeline
  fdm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .entry_in  (front_entry),
    .pop       (q_pop),
    .entry_out (back_entry),
    .status    (q_status)
  );

  // back: average, mix, motor mapping
  fdm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .entry       (back_entry),
    .q_empty     (q_status.empty),
    .pop         (q_pop),
    .motor_valid (motor_valid),
    .motor_stall (motor_stall),
    .motor       (motor)
  );

`ifndef SYNTHESIS
  // front never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_status.full)
    else $error("queue written while full");

  // back never reads an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_status.empty)
    else $error("queue read while empty");

  // a stopped motor carries no duty
  a_stop_duty: assert property (@(posedge clk) disable iff (rst)
    (motor_valid && (motor.left_direction == DIR_STOP || motor.right_direction == DIR_STOP))
    |-> ((motor.left_direction != DIR_STOP || motor.left_duty == '0) &&
         (motor.right_direction != DIR_STOP || motor.right_duty == '0)))
    else $error("stopped motor with nonzero duty");
`endif

endmodule

>>> tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the filtered differential drive mixer
// ---------------------------------------------------------------------------
// Joystick sample pairs go in through the sample channel. A local model of the
// two boxcar windows, the arcade mix and the motor mapping predicts every
// motor transfer, and each one that leaves is checked field by field. Both
// sides idle and stall at random. The register settings change between
// phases, and include the extremes and crossed deadbands.
// ---------------------------------------------------------------------------
module tb;
  import fdm_pkg::*;

  // index past the last register, writes to it must be dropped
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [SAMPLE_W-1:0] LEVEL_MIN = '0;
  localparam logic [SAMPLE_W-1:0] LEVEL_MAX = '1;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int DUTY_MAX     = (1 << DUTY_W) - 1;
  localparam int PRINT_CAP    = 20;
  localparam int PHASES       = 16;
  localparam int RANDOM_ITEMS = 1586;
  localparam int BURST_ITEMS  = 40;
  localparam int HOLD_CYCLES  = 80;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  sample_t             sample = '0;
  logic                motor_valid;
  logic                motor_stall = 1'b0;
  motor_t              motor;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  filtered_differential_drive_mixer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .motor_valid  (motor_valid),
    .motor_stall  (motor_stall),
    .motor        (motor),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // ---- local copy of the filter and mixer state ----
  logic [SAMPLE_W-1:0] vert_hist [WINDOW];
  logic [SAMPLE_W-1:0] horiz_hist [WINDOW];
  int                  vert_sum;
  int                  horiz_sum;
  int                  hist_slot;
  logic [SAMPLE_W-1:0] centre_q;
  logic [SAMPLE_W-1:0] db_high_q;
  logic [SAMPLE_W-1:0] db_low_q;

  // motor results still to come, oldest first
  motor_t pending_motor [$];

  int error_count     = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int config_writes   = 0;
  int stalled_offers  = 0;

  // sender burst state
  int burst_left = 0;

  // receiver state: a long hold-off on request, otherwise a changing style
  int   hold_request = 0;
  int   hold_left    = 0;
  int   stall_style  = 0;
  int   style_left   = 0;
  int   run_left     = 0;
  logic run_on       = 1'b0;

  // windows come out of reset holding 511, whatever the centre register says
  function automatic void clear_filter();
    int i;
    for (i = 0; i < WINDOW; i++) begin
      vert_hist[i]  = WINDOW_FILL;
      horiz_hist[i] = WINDOW_FILL;
    end
    vert_sum  = WINDOW * int'(WINDOW_FILL);
    horiz_sum = WINDOW * int'(WINDOW_FILL);
    hist_slot = 0;
    centre_q  = CENTRE_RESET;
    db_high_q = DB_HIGH_RESET;
    db_low_q  = DB_LOW_RESET;
  endfunction

  function automatic int clamp_sample(int x);
    if (x > SAMPLE_MAX) return SAMPLE_MAX;
    if (x < 0) return 0;
    return x;
  endfunction

  // motor value to direction and duty; forward is tested first, so it wins
  // when the deadband is crossed, and a duty below zero saturates at zero
  function automatic motor_side_t drive_side(int m);
    motor_side_t r;
    int d;
    if (m > int'(db_high_q)) begin
      r.direction = DIR_FWD;
      d = (m - int'(FWD_ZERO)) / 2;
    end else if (m < int'(db_low_q)) begin
      r.direction = DIR_BWD;
      d = (int'(BWD_ZERO) - m) / 2;
    end else begin
      r.direction = DIR_STOP;
      d = 0;
    end
    if (d < 0) d = 0;
    if (d > DUTY_MAX) d = DUTY_MAX;
    r.duty = DUTY_W'(d);
    return r;
  endfunction

  // push one pair into the windows and work out both motor outputs
  function automatic motor_t filter_and_mix(sample_t s);
    motor_t      r;
    motor_side_t ls;
    motor_side_t rs;
    int          vavg;
    int          havg;
    int          half;
    int          lm;
    int          rm;
    vert_sum  = vert_sum - int'(vert_hist[hist_slot]) + int'(s.vertical_sample);
    horiz_sum = horiz_sum - int'(horiz_hist[hist_slot]) + int'(s.horizontal_sample);
    vert_hist[hist_slot]  = s.vertical_sample;
    horiz_hist[hist_slot] = s.horizontal_sample;
    hist_slot = (hist_slot + 1) % WINDOW;
    vavg = vert_sum / WINDOW;
    havg = horiz_sum / WINDOW;
    // steer only outside the horizontal deadband, half offset toward zero
    if (havg > int'(db_high_q) || havg < int'(db_low_q)) begin
      half = (havg - int'(centre_q)) / 2;
      lm = clamp_sample(vavg - half);
      rm = clamp_sample(vavg + half);
    end else begin
      lm = vavg;
      rm = vavg;
    end
    ls = drive_side(lm);
    rs = drive_side(rm);
    r.left_duty       = ls.duty;
    r.left_direction  = ls.direction;
    r.right_duty      = rs.duty;
    r.right_direction = rs.direction;
    return r;
  endfunction

  // ---- reporting and checking ----
  task automatic log_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_motor_transfer(input motor_t got);
    motor_t want;
    if (pending_motor.size() == 0) begin
      log_mismatch($sformatf("motor transfer %h with nothing pending", got));
      return;
    end
    want = pending_motor.pop_front();
    if (got.left_duty !== want.left_duty)
      log_mismatch($sformatf("result %0d left_duty got %0d want %0d",
                             results_checked, got.left_duty, want.left_duty));
    if (got.left_direction !== want.left_direction)
      log_mismatch($sformatf("result %0d left_direction got %0d want %0d",
                             results_checked, got.left_direction, want.left_direction));
    if (got.right_duty !== want.right_duty)
      log_mismatch($sformatf("result %0d right_duty got %0d want %0d",
                             results_checked, got.right_duty, want.right_duty));
    if (got.right_direction !== want.right_direction)
      log_mismatch($sformatf("result %0d right_direction got %0d want %0d",
                             results_checked, got.right_direction, want.right_direction));
    results_checked++;
  endtask

  // samples values just before the edge, the same values the block sees
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_stall) stalled_offers++;
      if (motor_valid && !motor_stall) check_motor_transfer(motor);
    end
  end

  // ---- receiver: motor_stall ----
  // a requested hold-off keeps the channel stalled for a counted stretch;
  // otherwise the stall style changes after a stretch of random length
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      motor_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left  = $urandom_range(20, 300);
      end
      style_left--;
      case (stall_style)
        0: motor_stall <= 1'b0;                             // free running
        1: motor_stall <= ($urandom_range(0, 4) == 0);      // light stalls
        2: motor_stall <= ($urandom_range(0, 9) < 7);       // heavy stalls
        default: begin                                      // on/off runs
          if (run_left == 0) begin
            run_on   = !run_on;
            run_left = $urandom_range(1, 12);
          end
          run_left--;
          motor_stall <= run_on;
        end
      endcase
    end
  end

  // ---- sender side ----
  // every task below starts and ends just after a rising edge

  // offer one pair and hold it until the transfer; stall is stable from the
  // falling edge on, since all inputs change only at the rising edge
  task automatic send_sample(input sample_t s);
    logic taken;
    sample_valid <= 1'b1;
    sample       <= s;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !sample_stall;
      @(posedge clk);
    end
    pending_motor.push_back(filter_and_mix(s));
    items_sent++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      sample_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // bursts of random length with random gaps in between
  task automatic offer_sample(input sample_t s);
    if (burst_left == 0) begin
      if ($urandom_range(0, 5) != 0) pause_sender($urandom_range(1, 8));
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(60, 150);
      else burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    send_sample(s);
  endtask

  // stop offering and wait for every pending motor result
  task automatic wait_drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending_motor.size() != 0);
  endtask

  // leaves cfg_we high; the caller lowers it after the last write
  task automatic write_register(input logic [1:0] idx, input logic [SAMPLE_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_CENTRE:  centre_q  = val;
      REG_DB_HIGH: db_high_q = val;
      REG_DB_LOW:  db_low_q  = val;
      default: ;  // no such register
    endcase
    config_writes++;
  endtask

  // registers change only with the block empty
  task automatic apply_config(input logic [SAMPLE_W-1:0] centre,
                              input logic [SAMPLE_W-1:0] high,
                              input logic [SAMPLE_W-1:0] low);
    wait_drain();
    write_register(REG_CENTRE, centre);
    write_register(REG_DB_HIGH, high);
    write_register(REG_DB_LOW, low);
    cfg_we <= 1'b0;
  endtask

  // extreme levels or any level now and then, otherwise inside the given span
  function automatic logic [SAMPLE_W-1:0] pick_level(int lo, int hi);
    case ($urandom_range(0, 7))
      0: return LEVEL_MIN;
      1: return LEVEL_MAX;
      2: return SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      default: return SAMPLE_W'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic int pick_axis();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return SAMPLE_MAX;
      2: return $urandom_range(440, 580);
      default: return $urandom_range(0, SAMPLE_MAX);
    endcase
  endfunction

  function automatic sample_t make_pair(int v, int h);
    sample_t s;
    s.vertical_sample   = SAMPLE_W'(clamp_sample(v));
    s.horizontal_sample = SAMPLE_W'(clamp_sample(h));
    return s;
  endfunction

  // ---- tests ----

  // first items after reset: windows must start at 511 even with centre 0
  task automatic test_window_reset();
    apply_config(LEVEL_MIN, SAMPLE_W'(520), DB_LOW_RESET);
    send_sample(make_pair(511, 511));
    send_sample(make_pair(SAMPLE_MAX, 0));
    send_sample(make_pair(0, SAMPLE_MAX));
    send_sample(make_pair(511, SAMPLE_MAX));
  endtask

  task automatic test_field_extremes();
    apply_config(CENTRE_RESET, DB_HIGH_RESET, DB_LOW_RESET);
    send_sample(make_pair(0, 0));
    send_sample(make_pair(SAMPLE_MAX, SAMPLE_MAX));
    send_sample(make_pair(0, SAMPLE_MAX));
    send_sample(make_pair(SAMPLE_MAX, 0));
    send_sample(make_pair('h155, 'h2AA));
    send_sample(make_pair('h2AA, 'h155));
    send_sample(make_pair(SAMPLE_MAX, SAMPLE_MAX));
    send_sample(make_pair(SAMPLE_MAX, SAMPLE_MAX));
  endtask

  // a write to a missing register must leave all three untouched
  task automatic test_unused_register();
    wait_drain();
    write_register(REG_UNUSED, SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
    cfg_we <= 1'b0;
    send_sample(make_pair(600, 300));
    send_sample(make_pair(400, 700));
  endtask

  // forward just above a low deadband_high, backward just below a high
  // deadband_low: both give a negative raw duty that must saturate at zero
  task automatic test_duty_saturation();
    apply_config(CENTRE_RESET, SAMPLE_W'(480), DB_LOW_RESET);
    send_sample(make_pair(511, 511));
    send_sample(make_pair(520, 511));
    send_sample(make_pair(500, 511));
    apply_config(CENTRE_RESET, SAMPLE_W'(600), SAMPLE_W'(540));
    send_sample(make_pair(511, 511));
    send_sample(make_pair(480, 511));
    send_sample(make_pair(530, 511));
  endtask

  // low above high: forward test comes first
  task automatic test_crossed_deadband();
    apply_config(CENTRE_RESET, SAMPLE_W'(300), SAMPLE_W'(700));
    send_sample(make_pair(0, 0));
    send_sample(make_pair(SAMPLE_MAX, SAMPLE_MAX));
    send_sample(make_pair(511, 200));
    send_sample(make_pair(100, 900));
  endtask

  // receiver holds off while the sender keeps offering back to back, so the
  // queue fills and the input stalls; then the sender waits for every result
  task automatic test_backpressure();
    int k;
    wait_drain();
    hold_request = HOLD_CYCLES;
    for (k = 0; k < BURST_ITEMS; k++)
      send_sample(make_pair($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX)));
    wait_drain();
  endtask

  // mostly held stick positions with sensor jitter and sweeps between two
  // positions, long enough to drag the averages anywhere; some raw noise
  task automatic drive_random_moves(input int count);
    int done;
    int kind;
    int len;
    int jit;
    int k;
    int v0;
    int h0;
    int v1;
    int h1;
    int v;
    int h;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 9);
      v0 = pick_axis();
      h0 = pick_axis();
      v1 = pick_axis();
      h1 = pick_axis();
      jit = $urandom_range(0, 12);
      if (kind < 6) len = $urandom_range(10, 70);
      else if (kind < 9) len = $urandom_range(20, 60);
      else len = $urandom_range(1, 15);
      for (k = 0; k < len && done < count; k++) begin
        if (kind < 6) begin
          v = v0 + int'($urandom_range(0, 2 * jit)) - jit;
          h = h0 + int'($urandom_range(0, 2 * jit)) - jit;
        end else if (kind < 9) begin
          v = v0 + (v1 - v0) * k / len;
          h = h0 + (h1 - h0) * k / len;
        end else begin
          v = $urandom_range(0, SAMPLE_MAX);
          h = $urandom_range(0, SAMPLE_MAX);
        end
        offer_sample(make_pair(v, h));
        done++;
      end
    end
  endtask

  // each phase gets its own register setting; the first few are fixed corners
  task automatic test_random_phases();
    int phase;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: apply_config(CENTRE_RESET, DB_HIGH_RESET, DB_LOW_RESET);
        1: apply_config(LEVEL_MIN, LEVEL_MAX, LEVEL_MIN);   // never leaves the deadband
        2: apply_config(LEVEL_MAX, LEVEL_MIN, LEVEL_MAX);   // always outside it
        3: apply_config(CENTRE_RESET, SAMPLE_W'(300), SAMPLE_W'(700));
        default: apply_config(pick_level(400, 620), pick_level(470, 700),
                              pick_level(300, 560));
      endcase
      drive_random_moves(RANDOM_ITEMS / PHASES);
    end
  endtask

  // ---- main sequence ----
  initial begin
    clear_filter();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_window_reset();
    test_field_extremes();
    test_unused_register();
    test_duty_saturation();
    test_crossed_deadband();
    test_backpressure();
    test_random_phases();
    wait_drain();
    // let anything unexpected fall out of the pipeline
    repeat (20) @(posedge clk);
    $display("run: %0d sample pairs, %0d motor results checked, %0d register writes",
             items_sent, results_checked, config_writes);
    $display("input held off on %0d offered cycles; corner and crossed deadbands included",
             stalled_offers);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d motor results still pending", pending_motor.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
